>>> rtl/core/b64d_pkg.sv
// Shared types and constants for the base64 stream decoder.
`timescale 1ns / 1ps

package b64d_pkg;

    // Largest destination size honored, whatever the limit register holds
    localparam logic [12:0] MAX_OUTPUT_BYTES = 13'd4096;

    // Limit register reset value
    localparam logic [12:0] LIMIT_RESET = 13'd32;

    // Completion status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADCHAR = 2'd1,
        ST_LIMIT   = 2'd2,
        ST_PAD     = 2'd3
    } status_t;

    // Padding progress
    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_OWED = 2'd1,
        PAD_DONE = 2'd2
    } pad_stage_t;

    // Decoder state carried from item to item
    typedef struct packed {
        logic [1:0]  group_position;
        pad_stage_t  pad_stage;
        logic [7:0]  partial_byte;
        logic [12:0] out_count;
        status_t     error_code;
    } dec_state_t;

    // One result item
    typedef struct packed {
        logic        emit;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        done_res;
        status_t     status;
        logic [12:0] byte_count;
    } dec_result_t;

endpackage

>>> rtl/core/b64d_decode.sv
// Per-character decode step: next decoder state and the result item it causes.
`timescale 1ns / 1ps

module b64d_decode
    import b64d_pkg::*;
(
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    input  logic [12:0] limit,
    input  dec_state_t  cur,
    output dec_state_t  nxt,
    output dec_result_t res
);

    localparam logic [7:0] CH_PAD = 8'h3D;

    // Whitespace: tab through carriage return, and space
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    // Alphabet lookup: {hit, six-bit value}
    function automatic logic [6:0] sextet(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if ((c >= 8'h41) && (c <= 8'h5A)) begin
            d = c - 8'h41;
            return {1'b1, d[5:0]};
        end
        if ((c >= 8'h61) && (c <= 8'h7A)) begin
            d = c - 8'h47;
            return {1'b1, d[5:0]};
        end
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            d = c + 8'h04;
            return {1'b1, d[5:0]};
        end
        if (c == 8'h2B) return {1'b1, 6'd62};
        if (c == 8'h2F) return {1'b1, 6'd63};
        return {1'b0, 6'd0};
    endfunction

    logic [12:0] lim;
    logic [13:0] cnt_inc;
    logic        at_lim;
    logic        near_lim;
    logic [6:0]  sx;
    logic [5:0]  v;

    // Clamp the limit and form the two limit checks
    assign lim      = (limit > MAX_OUTPUT_BYTES) ? MAX_OUTPUT_BYTES : limit;
    assign cnt_inc  = {1'b0, cur.out_count} + 14'd1;
    assign at_lim   = cur.out_count >= lim;
    assign near_lim = cnt_inc >= {1'b0, lim};
    assign sx       = sextet(char_code);
    assign v        = sx[5:0];

    always_comb
    begin
        nxt            = cur;
        res.emit       = 1'b0;
        res.data_byte  = 8'h00;
        res.byte_valid = 1'b0;
        res.done_res   = 1'b0;
        res.status     = ST_OK;
        res.byte_count = cur.out_count;

        if (end_of_text)
        begin
            // Report final status, then clear for the next string
            res.emit     = 1'b1;
            res.done_res = 1'b1;
            res.status   = cur.error_code;
            if ((cur.error_code == ST_OK) &&
                (((cur.pad_stage == PAD_NONE) && (cur.group_position != 2'd0)) ||
                 (cur.pad_stage == PAD_OWED)))
            begin
                res.status = ST_PAD;
            end
            nxt.group_position = 2'd0;
            nxt.pad_stage      = PAD_NONE;
            nxt.partial_byte   = 8'h00;
            nxt.out_count      = 13'd0;
            nxt.error_code     = ST_OK;
        end
        else if ((cur.error_code != ST_OK) || is_blank(char_code))
        begin
            // Hold everything
        end
        else if (cur.pad_stage != PAD_NONE)
        begin
            // Only a second owed pad may follow padding
            if ((cur.pad_stage == PAD_OWED) && (char_code == CH_PAD))
            begin
                nxt.pad_stage = PAD_DONE;
                if (cur.partial_byte != 8'h00)
                    nxt.error_code = ST_PAD;
            end
            else
            begin
                nxt.error_code = ST_PAD;
            end
        end
        else if (char_code == CH_PAD)
        begin
            // First pad: legal only at positions 2 and 3
            unique case (cur.group_position)
                2'd2:
                begin
                    nxt.pad_stage = PAD_OWED;
                end
                2'd3:
                begin
                    nxt.pad_stage = PAD_DONE;
                    if (cur.partial_byte != 8'h00)
                        nxt.error_code = ST_PAD;
                end
                default:
                begin
                    nxt.error_code = ST_PAD;
                end
            endcase
        end
        else if (!sx[6])
        begin
            nxt.error_code = ST_BADCHAR;
        end
        else
        begin
            // Advance the group, emitting a byte at positions 1 to 3
            unique case (cur.group_position)
                2'd0:
                begin
                    if (at_lim)
                        nxt.error_code = ST_LIMIT;
                    else
                    begin
                        nxt.partial_byte   = {v, 2'b00};
                        nxt.group_position = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (near_lim)
                        nxt.error_code = ST_LIMIT;
                    else
                    begin
                        res.emit           = 1'b1;
                        res.data_byte      = cur.partial_byte | {4'h0, v[5:4]};
                        nxt.partial_byte   = {v[3:0], 4'h0};
                        nxt.group_position = 2'd2;
                    end
                end
                2'd2:
                begin
                    if (near_lim)
                        nxt.error_code = ST_LIMIT;
                    else
                    begin
                        res.emit           = 1'b1;
                        res.data_byte      = cur.partial_byte | {2'b00, v[5:2]};
                        nxt.partial_byte   = {v[1:0], 6'h00};
                        nxt.group_position = 2'd3;
                    end
                end
                default:
                begin
                    if (at_lim)
                        nxt.error_code = ST_LIMIT;
                    else
                    begin
                        res.emit           = 1'b1;
                        res.data_byte      = cur.partial_byte | {2'b00, v};
                        nxt.partial_byte   = 8'h00;
                        nxt.group_position = 2'd0;
                    end
                end
            endcase

            if (res.emit)
            begin
                res.byte_valid = 1'b1;
                nxt.out_count  = cnt_inc[12:0];
                res.byte_count = cnt_inc[12:0];
            end
        end
    end

endmodule

>>> rtl/core/b64d_cfg.sv
// APB register block holding the output limit.
`timescale 1ns / 1ps

module b64d_cfg
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [12:0] limit
);

    logic [12:0] limit_reg;
    logic [12:0] limit_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == 1'b0);

    // Take the low 13 bits on a write to the limit register
    always_comb
    begin
        limit_next = limit_reg;
        if (wr_en)
            limit_next = pwdata[12:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else
            limit_reg <= limit_next;
    end

    assign prdata = (paddr[2] == 1'b0) ? {19'd0, limit_reg} : 32'd0;
    assign limit  = limit_reg;

endmodule

>>> rtl/core/base64_stream_decoder_unit.sv
// Top level of the base64 stream decoder: input register, decode step, result register.
`timescale 1ns / 1ps
// A character is held in the input register until the result register is free to take it.
// Throughput: one character per cycle while results are taken; the input register and
// the result register let the next character enter while a result waits to be taken.
// Reset: rst_n clears the decode state and both valid flags at once and sets
// the output limit to 32; no clearing pass is needed.

module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_text
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [9:8] status, [22:10] byte_count
    output logic        m_tlast,   // done_res
    output logic        m_tuser,   // byte_valid
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_eot_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t res;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_bvalid_reg;
    logic        out_done_reg;
    status_t     out_status_reg;
    logic [12:0] out_count_reg;
    logic [12:0] limit;
    logic        in_take;
    logic        step;

    b64d_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    b64d_decode u_decode (
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .limit       (limit),
        .cur         (state_reg),
        .nxt         (state_next),
        .res         (res)
    );

    // Advance the held item once the result slot is free or being emptied
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg && !m_tready;
        if (step)
            out_valid_next = res.emit;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            state_reg.group_position <= 2'd0;
            state_reg.pad_stage      <= PAD_NONE;
            state_reg.partial_byte   <= 8'h00;
            state_reg.out_count      <= 13'd0;
            state_reg.error_code     <= ST_OK;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step)
                state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
        if (step && res.emit)
        begin
            out_byte_reg   <= res.data_byte;
            out_bvalid_reg <= res.byte_valid;
            out_done_reg   <= res.done_res;
            out_status_reg <= res.status;
            out_count_reg  <= res.byte_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_status_reg, out_byte_reg};
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_bvalid_reg;

endmodule
